/* design/tsga_pkg.sv */
// shared constants and types for the tree split gain accumulator
package tsga_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ACC_WIDTH  = 48;
    localparam int COUNT_BITS = 24;

    // improvement is Q31.32, so the exact quotient is scaled up by this shift
    localparam int SCALE_SH = 32 - FRAC_BITS;

    // multi-word arithmetic on 32-bit limbs
    localparam int LIMB = 32;
    localparam int XL   = (4 * ACC_WIDTH + 2 + LIMB - 1) / LIMB;
    localparam int YL   = (2 * ACC_WIDTH + 1 + LIMB - 1) / LIMB;
    localparam int XW   = XL * LIMB;
    localparam int YW   = YL * LIMB;
    localparam int PW   = ((5 * ACC_WIDTH + 4 + LIMB - 1) / LIMB) * LIMB;
    localparam int QW   = 63;
    localparam int DW   = PW + QW + 1;

    localparam int QDEPTH = 2;
    localparam int CFG_W  = 24;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LEFT  = 2'd1;
    localparam logic [1:0] CMD_MISS  = 2'd2;

    localparam logic CFG_MIN_OBS = 1'b0;
    localparam logic CFG_MONO    = 1'b1;

    localparam logic [1:0] MONO_NONE = 2'b00;
    localparam logic [1:0] MONO_INC  = 2'b01;

    typedef logic [ACC_WIDTH-1:0]  t_acc;
    typedef logic [COUNT_BITS-1:0] t_cnt;

    // snapshot of the node after one item, handed from front to back
    typedef struct packed {
        t_acc        rl;
        t_acc        rr;
        t_acc        rm;
        t_acc        wl;
        t_acc        wr;
        t_acc        wm;
        t_cnt        left_obs;
        t_cnt        right_obs;
        t_cnt        miss_obs;
        logic        min_ok;
        logic [31:0] split_value;
        logic [15:0] split_var;
        logic [15:0] split_class;
    } t_job;

    typedef struct packed {
        logic [QW-1:0] improvement;
        logic          eval_valid;
        logic          monotone_ok;
        logic          min_obs_ok;
        t_cnt          left_count;
        t_cnt          right_count;
        t_cnt          missing_count;
        logic [31:0]   split_value;
        logic [15:0]   split_var;
        logic [15:0]   split_class;
    } t_res;

endpackage

/* design/tsga_front.sv */
// front end: configuration registers and the left/right/missing accumulators
module tsga_front import tsga_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_accept,
    input  logic [1:0]         i_cmd,
    input  logic [31:0]        i_residual,
    input  logic [31:0]        i_weight,
    input  logic [23:0]        i_count,
    input  logic [31:0]        i_split_value_in,
    input  logic [15:0]        i_split_var_in,
    input  logic [15:0]        i_class_count,
    output t_job               o_job,
    output logic [1:0]         o_mono_mode
);

    localparam int CSW = 34;
    localparam logic [CSW-1:0] CNT_MAX = (CSW'(1) << COUNT_BITS) - CSW'(1);
    localparam t_acc SMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam t_acc SMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic [CFG_W-1:0] r_min_obs;
    logic [1:0]       r_mono_mode;

    t_acc        r_rl, r_rr, r_rm, r_wl, r_wr, r_wm;
    t_cnt        r_lo, r_ro, r_mo;
    logic [31:0] r_sval;
    logic [15:0] r_svar, r_scls;

    t_acc        n_rl, n_rr, n_rm, n_wl, n_wr, n_wm;
    t_cnt        n_lo, n_ro, n_mo;
    logic [31:0] n_sval;
    logic [15:0] n_svar, n_scls;

    t_acc res_ext, res_neg, wt_ext;
    t_cnt cnt_sat;

    function automatic t_acc sat_sadd(input t_acc a, input t_acc d);
        logic [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} + {d[ACC_WIDTH-1], d};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            sat_sadd = s[ACC_WIDTH] ? SMIN : SMAX;
        end else begin
            sat_sadd = s[ACC_WIDTH-1:0];
        end
    endfunction

    function automatic t_acc sat_uadd(input t_acc a, input t_acc d);
        logic [ACC_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, d};
        sat_uadd = s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
    endfunction

    function automatic t_cnt sat_cadd(input t_cnt a, input logic [23:0] d);
        logic [CSW-1:0] s;
        s = CSW'(a) + CSW'(d);
        sat_cadd = (s > CNT_MAX) ? t_cnt'(CNT_MAX) : t_cnt'(s);
    endfunction

    function automatic t_cnt floor_csub(input t_cnt a, input logic [23:0] d);
        floor_csub = (CSW'(d) > CSW'(a)) ? '0 : t_cnt'(CSW'(a) - CSW'(d));
    endfunction

    always_comb begin
        res_ext = {{(ACC_WIDTH-32){i_residual[31]}}, i_residual};
        res_neg = ~res_ext + t_acc'(1);
        wt_ext  = t_acc'(i_weight);
        cnt_sat = (CSW'(i_count) > CNT_MAX) ? t_cnt'(CNT_MAX) : t_cnt'(i_count);

        n_rl = r_rl; n_rr = r_rr; n_rm = r_rm;
        n_wl = r_wl; n_wr = r_wr; n_wm = r_wm;
        n_lo = r_lo; n_ro = r_ro; n_mo = r_mo;
        n_sval = r_sval; n_svar = r_svar; n_scls = r_scls;

        case (i_cmd) inside
            CMD_START: begin
                n_rr = res_ext;
                n_wr = wt_ext;
                n_ro = cnt_sat;
                n_rl = '0; n_wl = '0; n_lo = '0;
                n_rm = '0; n_wm = '0; n_mo = '0;
                n_sval = i_split_value_in;
                n_svar = i_split_var_in;
                n_scls = i_class_count;
            end
            CMD_LEFT, CMD_MISS: begin
                if (i_cmd == CMD_LEFT) begin
                    n_rl = sat_sadd(r_rl, res_ext);
                    n_wl = sat_uadd(r_wl, wt_ext);
                    n_lo = sat_cadd(r_lo, i_count);
                end else begin
                    n_rm = sat_sadd(r_rm, res_ext);
                    n_wm = sat_uadd(r_wm, wt_ext);
                    n_mo = sat_cadd(r_mo, i_count);
                end
                n_rr = sat_sadd(r_rr, res_neg);
                n_wr = (wt_ext > r_wr) ? '0 : r_wr - wt_ext;
                n_ro = floor_csub(r_ro, i_count);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_obs   <= CFG_W'(1);
            r_mono_mode <= MONO_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_OBS: r_min_obs   <= i_cfg_data;
                CFG_MONO:    r_mono_mode <= i_cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl <= '0; r_rr <= '0; r_rm <= '0;
            r_wl <= '0; r_wr <= '0; r_wm <= '0;
            r_lo <= '0; r_ro <= '0; r_mo <= '0;
            r_sval <= '0; r_svar <= '0; r_scls <= '0;
        end else if (i_accept) begin
            r_rl <= n_rl; r_rr <= n_rr; r_rm <= n_rm;
            r_wl <= n_wl; r_wr <= n_wr; r_wm <= n_wm;
            r_lo <= n_lo; r_ro <= n_ro; r_mo <= n_mo;
            r_sval <= n_sval; r_svar <= n_svar; r_scls <= n_scls;
        end
    end

    always_comb begin
        o_job.rl          = n_rl;
        o_job.rr          = n_rr;
        o_job.rm          = n_rm;
        o_job.wl          = n_wl;
        o_job.wr          = n_wr;
        o_job.wm          = n_wm;
        o_job.left_obs    = n_lo;
        o_job.right_obs   = n_ro;
        o_job.miss_obs    = n_mo;
        o_job.min_ok      = (CSW'(n_lo) >= CSW'(r_min_obs)) && (CSW'(n_ro) >= CSW'(r_min_obs));
        o_job.split_value = n_sval;
        o_job.split_var   = n_svar;
        o_job.split_class = n_scls;
    end

    assign o_mono_mode = r_mono_mode;

endmodule

/* design/tsga_queue.sv */
// two-entry job queue between the accumulator front end and the gain engine
module tsga_queue import tsga_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PTW = $clog2(QDEPTH);
    localparam int CTW = $clog2(QDEPTH + 1);

    t_job           r_mem [QDEPTH];
    logic [PTW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CTW-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CTW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTW'(QDEPTH - 1)) ? '0 : r_wr_ptr + PTW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTW'(QDEPTH - 1)) ? '0 : r_rd_ptr + PTW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CTW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CTW'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CTW'(QDEPTH))
        else $error("queue fill count beyond depth");

endmodule

/* design/tsga_back.sv */
// back end: limb-serial multiplier sequencer and restoring divider for the gain
module tsga_back import tsga_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_mono_mode,
    input  t_job       i_job,
    input  logic       i_job_valid,
    output logic       o_job_pop,
    output t_res       o_res,
    output logic       o_res_valid,
    input  logic       i_res_pop
);

    localparam int XIW = $clog2(XL);
    localparam int KW  = $clog2(XL + 1);
    localparam int JW  = $clog2(YL);
    localparam int DCW = $clog2(QW + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_POST  = 3'd2;
    localparam logic [2:0] ST_ABS   = 3'd3;
    localparam logic [2:0] ST_DINIT = 3'd4;
    localparam logic [2:0] ST_DCHK  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // multiplicand sources
    localparam logic [2:0] XS_RL = 3'd0;
    localparam logic [2:0] XS_RR = 3'd1;
    localparam logic [2:0] XS_RM = 3'd2;
    localparam logic [2:0] XS_WL = 3'd3;
    localparam logic [2:0] XS_D  = 3'd4;
    localparam logic [2:0] XS_S  = 3'd5;
    localparam logic [2:0] XS_Q  = 3'd6;

    // multiplier sources
    localparam logic [2:0] YS_WL = 3'd0;
    localparam logic [2:0] YS_WR = 3'd1;
    localparam logic [2:0] YS_WM = 3'd2;
    localparam logic [2:0] YS_D  = 3'd3;
    localparam logic [2:0] YS_W2 = 3'd4;
    localparam logic [2:0] YS_W3 = 3'd5;

    // what happens to a finished product
    localparam logic [2:0] ACT_T1   = 3'd0;
    localparam logic [2:0] ACT_DLR  = 3'd1;
    localparam logic [2:0] ACT_D    = 3'd2;
    localparam logic [2:0] ACT_S    = 3'd3;
    localparam logic [2:0] ACT_ACC0 = 3'd4;
    localparam logic [2:0] ACT_ACCA = 3'd5;
    localparam logic [2:0] ACT_Q    = 3'd6;
    localparam logic [2:0] ACT_DEN  = 3'd7;

    typedef struct packed {
        logic [2:0] xs;
        logic [2:0] ys;
        logic [2:0] act;
        logic       last;
    } t_step;

    // operation list: cross products, squares, weighted sum, denominator
    function automatic t_step prog_step(input logic three, input logic [3:0] idx);
        t_step s;
        s = '{xs: XS_Q, ys: YS_W3, act: ACT_DEN, last: 1'b1};
        if (!three) begin
            unique case (idx)
                4'd0:    s = '{xs: XS_RL, ys: YS_WR, act: ACT_T1,   last: 1'b0};
                4'd1:    s = '{xs: XS_RR, ys: YS_WL, act: ACT_DLR,  last: 1'b0};
                4'd2:    s = '{xs: XS_D,  ys: YS_D,  act: ACT_ACC0, last: 1'b0};
                4'd3:    s = '{xs: XS_WL, ys: YS_WR, act: ACT_Q,    last: 1'b0};
                default: s = '{xs: XS_Q,  ys: YS_W2, act: ACT_DEN,  last: 1'b1};
            endcase
        end else begin
            unique case (idx)
                4'd0:    s = '{xs: XS_RL, ys: YS_WR, act: ACT_T1,   last: 1'b0};
                4'd1:    s = '{xs: XS_RR, ys: YS_WL, act: ACT_DLR,  last: 1'b0};
                4'd2:    s = '{xs: XS_D,  ys: YS_D,  act: ACT_S,    last: 1'b0};
                4'd3:    s = '{xs: XS_S,  ys: YS_WM, act: ACT_ACC0, last: 1'b0};
                4'd4:    s = '{xs: XS_RL, ys: YS_WM, act: ACT_T1,   last: 1'b0};
                4'd5:    s = '{xs: XS_RM, ys: YS_WL, act: ACT_D,    last: 1'b0};
                4'd6:    s = '{xs: XS_D,  ys: YS_D,  act: ACT_S,    last: 1'b0};
                4'd7:    s = '{xs: XS_S,  ys: YS_WR, act: ACT_ACCA, last: 1'b0};
                4'd8:    s = '{xs: XS_RR, ys: YS_WM, act: ACT_T1,   last: 1'b0};
                4'd9:    s = '{xs: XS_RM, ys: YS_WR, act: ACT_D,    last: 1'b0};
                4'd10:   s = '{xs: XS_D,  ys: YS_D,  act: ACT_S,    last: 1'b0};
                4'd11:   s = '{xs: XS_S,  ys: YS_WL, act: ACT_ACCA, last: 1'b0};
                4'd12:   s = '{xs: XS_WL, ys: YS_WR, act: ACT_Q,    last: 1'b0};
                4'd13:   s = '{xs: XS_Q,  ys: YS_WM, act: ACT_Q,    last: 1'b0};
                default: s = '{xs: XS_Q,  ys: YS_W3, act: ACT_DEN,  last: 1'b1};
            endcase
        end
        prog_step = s;
    endfunction

    function automatic t_acc smag(input t_acc v);
        smag = v[ACC_WIDTH-1] ? (~v + t_acc'(1)) : v;
    endfunction

    logic [2:0]      r_state;
    t_job            r_job;
    logic            r_three, r_valid, r_mono;
    logic [3:0]      r_step;
    logic [JW-1:0]   r_j;
    logic [KW-1:0]   r_k;
    logic [PW-1:0]   r_row, r_pacc, r_t1, r_d, r_num, r_den;
    logic [XW-1:0]   r_dmag, r_s, r_q;
    logic [DW-1:0]   r_rem, r_dsr;
    logic [QW-1:0]   r_quo;
    logic [DCW-1:0]  r_dcnt;
    t_res            r_out;
    logic            r_out_valid;

    t_step           cur;
    logic [XW-1:0]   x_vec;
    logic [YW-1:0]   y_vec;
    logic            sx;
    logic [XIW-1:0]  xi;
    logic [LIMB-1:0] x_limb, y_limb;
    logic [2*LIMB-1:0] prod;
    logic [PW-1:0]   n_row, n_pacc, sp, dmag_full;
    logic [DW:0]     diff;
    logic            d_neg, d_zero, n_mono, job_ok, out_free;

    assign cur = prog_step(r_three, r_step);

    always_comb begin
        case (cur.xs)
            XS_RL:   x_vec = XW'(smag(r_job.rl));
            XS_RR:   x_vec = XW'(smag(r_job.rr));
            XS_RM:   x_vec = XW'(smag(r_job.rm));
            XS_WL:   x_vec = XW'(r_job.wl);
            XS_D:    x_vec = r_dmag;
            XS_S:    x_vec = r_s;
            default: x_vec = r_q;
        endcase
        case (cur.xs)
            XS_RL:   sx = r_job.rl[ACC_WIDTH-1];
            XS_RR:   sx = r_job.rr[ACC_WIDTH-1];
            XS_RM:   sx = r_job.rm[ACC_WIDTH-1];
            default: sx = 1'b0;
        endcase
        case (cur.ys)
            YS_WL:   y_vec = YW'(r_job.wl);
            YS_WR:   y_vec = YW'(r_job.wr);
            YS_WM:   y_vec = YW'(r_job.wm);
            YS_D:    y_vec = r_dmag[YW-1:0];
            YS_W2:   y_vec = YW'(r_job.wl) + YW'(r_job.wr);
            default: y_vec = YW'(r_job.wl) + YW'(r_job.wr) + YW'(r_job.wm);
        endcase
    end

    // limbs of the multiplicand go most significant first
    assign xi     = XIW'(XL - 1) - r_k[XIW-1:0];
    assign x_limb = x_vec[xi * LIMB +: LIMB];
    assign y_limb = y_vec[r_j * LIMB +: LIMB];
    assign prod   = x_limb * y_limb;
    assign n_row  = {r_row[PW-LIMB-1:0], {LIMB{1'b0}}} + PW'(prod);
    assign n_pacc = {r_pacc[PW-LIMB-1:0], {LIMB{1'b0}}} + r_row;

    assign sp        = sx ? (~r_pacc + PW'(1)) : r_pacc;
    assign dmag_full = r_d[PW-1] ? (~r_d + PW'(1)) : r_d;
    assign d_neg     = r_d[PW-1];
    assign d_zero    = (r_d == '0);
    assign diff      = {1'b0, r_rem} - {1'b0, r_dsr};

    always_comb begin
        if (i_mono_mode == MONO_NONE) begin
            n_mono = 1'b1;
        end else if (i_mono_mode == MONO_INC) begin
            n_mono = d_neg;
        end else begin
            n_mono = !d_neg && !d_zero;
        end
    end

    assign job_ok = (i_job.miss_obs != '0)
                  ? (i_job.wl != '0 && i_job.wr != '0 && i_job.wm != '0)
                  : (i_job.wl != '0 && i_job.wr != '0);

    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;
    assign out_free  = !r_out_valid || i_res_pop;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job   <= i_job;
            r_three <= (i_job.miss_obs != '0);
            r_valid <= job_ok;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_step <= '0;
                r_j    <= JW'(YL - 1);
                r_k    <= '0;
                r_row  <= '0;
                r_pacc <= '0;
            end
            ST_MUL: begin
                if (r_k != KW'(XL)) begin
                    r_row <= n_row;
                    r_k   <= r_k + KW'(1);
                end else begin
                    r_pacc <= n_pacc;
                    r_row  <= '0;
                    r_k    <= '0;
                    r_j    <= r_j - JW'(1);
                end
            end
            ST_POST: begin
                case (cur.act)
                    ACT_T1:         r_t1  <= sp;
                    ACT_DLR, ACT_D: r_d   <= sx ? (r_t1 + r_pacc) : (r_t1 - r_pacc);
                    ACT_S:          r_s   <= r_pacc[XW-1:0];
                    ACT_ACC0:       r_num <= r_pacc;
                    ACT_ACCA:       r_num <= r_num + r_pacc;
                    ACT_Q:          r_q   <= r_pacc[XW-1:0];
                    default:        r_den <= r_pacc;
                endcase
                if (cur.act != ACT_DLR && cur.act != ACT_D) begin
                    r_step <= r_step + 4'd1;
                end
                r_j    <= JW'(YL - 1);
                r_pacc <= '0;
            end
            ST_ABS: begin
                r_dmag <= dmag_full[XW-1:0];
                if (cur.act == ACT_DLR) begin
                    r_mono <= n_mono;
                end
                r_step <= r_step + 4'd1;
            end
            ST_DINIT: begin
                r_rem <= DW'(r_num) << SCALE_SH;
                r_dsr <= DW'(r_den) << QW;
            end
            ST_DCHK: begin
                if (!r_valid) begin
                    r_quo <= '0;
                end else if (!diff[DW]) begin
                    r_quo <= '1;
                end else begin
                    r_quo  <= '0;
                    r_dsr  <= r_dsr >> 1;
                    r_dcnt <= DCW'(QW);
                end
            end
            ST_DIV: begin
                if (!diff[DW]) begin
                    r_rem <= diff[DW-1:0];
                end
                r_quo  <= {r_quo[QW-2:0], !diff[DW]};
                r_dsr  <= r_dsr >> 1;
                r_dcnt <= r_dcnt - DCW'(1);
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out.improvement   <= r_quo;
                    r_out.eval_valid    <= r_valid;
                    r_out.monotone_ok   <= r_mono;
                    r_out.min_obs_ok    <= r_job.min_ok;
                    r_out.left_count    <= r_job.left_obs;
                    r_out.right_count   <= r_job.right_obs;
                    r_out.missing_count <= r_job.miss_obs;
                    r_out.split_value   <= r_job.split_value;
                    r_out.split_var     <= r_job.split_var;
                    r_out.split_class   <= r_job.split_class;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace the one taken in the same cycle
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_res_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_k == KW'(XL) && r_j == '0) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (cur.act == ACT_DLR || cur.act == ACT_D) begin
                        r_state <= ST_ABS;
                    end else if (cur.last) begin
                        r_state <= ST_DINIT;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_ABS:   r_state <= ST_MUL;
                ST_DINIT: r_state <= ST_DCHK;
                ST_DCHK: begin
                    if (!r_valid || !diff[DW]) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.eval_valid |-> r_out.improvement == '0)
        else $error("improvement nonzero on an invalid evaluation");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_dcnt != '0)
        else $error("divider running with no quotient bits left");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT && r_out_valid && !i_res_pop |=> r_state == ST_OUT)
        else $error("result overwritten before its transaction");

endmodule

/* design/tree_split_gain_accumulator_unit.sv */
// Split improvement engine: each accepted item (start, move to left, move to
// missing) updates the node accumulators in the cycle it is taken and queues a
// snapshot; the back end then works out the exact improvement with one 32x32
// multiplier walked over 32-bit limbs and a one-bit-per-cycle restoring
// divider. Two further items are taken while one is in the works.
module tree_split_gain_accumulator_unit import tsga_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_cmd,
    input  logic signed [31:0]    i_residual,
    input  logic [31:0]           i_weight,
    input  logic [23:0]           i_count,
    input  logic signed [31:0]    i_split_value_in,
    input  logic [15:0]           i_split_var_in,
    input  logic [15:0]           i_class_count,
    output logic                  empty,
    input  logic                  pop,
    output logic [QW-1:0]         o_improvement,
    output logic                  o_eval_valid,
    output logic                  o_monotone_ok,
    output logic                  o_min_obs_ok,
    output logic [COUNT_BITS-1:0] o_left_count_out,
    output logic [COUNT_BITS-1:0] o_right_count_out,
    output logic [COUNT_BITS-1:0] o_missing_count_out,
    output logic signed [31:0]    o_split_value_out,
    output logic [15:0]           o_split_var_out,
    output logic [15:0]           o_split_class_out
);

    logic       accept;
    t_job       front_job, q_job;
    logic       q_empty, job_pop;
    logic [1:0] mono_mode;
    t_res       res;
    logic       res_valid;

    assign accept = push && !full;

    tsga_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_cmd            (i_cmd),
        .i_residual       (i_residual),
        .i_weight         (i_weight),
        .i_count          (i_count),
        .i_split_value_in (i_split_value_in),
        .i_split_var_in   (i_split_var_in),
        .i_class_count    (i_class_count),
        .o_job            (front_job),
        .o_mono_mode      (mono_mode)
    );

    tsga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_job),
        .i_pop   (job_pop),
        .o_data  (q_job),
        .o_full  (full),
        .o_empty (q_empty)
    );

    tsga_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mono_mode (mono_mode),
        .i_job       (q_job),
        .i_job_valid (!q_empty),
        .o_job_pop   (job_pop),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_pop   (pop)
    );

    assign empty               = !res_valid;
    assign o_improvement       = res.improvement;
    assign o_eval_valid        = res.eval_valid;
    assign o_monotone_ok       = res.monotone_ok;
    assign o_min_obs_ok        = res.min_obs_ok;
    assign o_left_count_out    = res.left_count;
    assign o_right_count_out   = res.right_count;
    assign o_missing_count_out = res.missing_count;
    assign o_split_value_out   = res.split_value;
    assign o_split_var_out     = res.split_var;
    assign o_split_class_out   = res.split_class;

endmodule
